FILE: rtl/core/pmmh_pkg.sv
package pmmh_pkg;

    localparam int HIST_BINS_DEF = 256;
    localparam int BYTE_BINS     = 64;
    localparam int GVAR_BINS     = 256;
    localparam int GVAR_SHIFT    = 5;
    localparam int BIN_SHIFT     = 2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    typedef enum logic [1:0] {
        OP_PIXEL = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BYTES_PER_PIXEL = 1'b0,
        CFG_GVAR_RAW_MODE   = 1'b1
    } cfg_idx_t;

    // one completed pixel from the byte assembler
    typedef struct packed {
        logic        done;
        logic        hist_en;
        logic        gvar;
        logic [31:0] value;
    } pix_t;

endpackage

FILE: rtl/core/pmmh_ram.sv
module pmmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read during write to the same entry returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/pmmh_assembler.sv
module pmmh_assembler (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         take,
    input  logic                         restart,
    input  logic [7:0]                   data_byte,
    input  logic [pmmh_pkg::CFG_DATA_W-1:0] bytes_per_pixel,
    input  logic                         gvar_raw_mode,
    output pmmh_pkg::pix_t               pix
);

    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic [1:0]  pos_reg;
    logic [1:0]  pos_next;
    logic [1:0]  last;
    logic        gvar;
    logic [31:0] shifted;

    // out-of-range byte counts fold onto 1 and 4
    always_comb
    begin
        unique case (bytes_per_pixel) inside
            3'd0, 3'd1: last = 2'd0;
            3'd2:       last = 2'd1;
            3'd3:       last = 2'd2;
            default:    last = 2'd3;
        endcase
    end

    assign gvar    = (last == 2'd1) && gvar_raw_mode;
    assign shifted = {acc_reg[23:0], data_byte};

    assign pix.done    = take && (pos_reg == last);
    assign pix.gvar    = gvar;
    assign pix.hist_en = gvar || (last == 2'd0);
    assign pix.value   = gvar ? (shifted >> pmmh_pkg::GVAR_SHIFT) : shifted;

    always_comb
    begin
        acc_next = acc_reg;
        pos_next = pos_reg;
        if (restart)
        begin
            acc_next = '0;
            pos_next = '0;
        end
        else if (take)
        begin
            if (pos_reg == last)
            begin
                acc_next = '0;
                pos_next = '0;
            end
            else
            begin
                acc_next = shifted;
                pos_next = pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            pos_reg <= pos_next;
        end
    end

endmodule

FILE: rtl/core/pixel_min_max_histogram.sv
// A read word is registered in the read-modify-write stage, then in the
// output or skid register. Throughput: one word per cycle for pixel bytes
// and reads when not stalled; histogram read-modify-write runs through a
// one-entry forwarding register. A clear word stalls the input while the
// histogram RAM is swept to zero, one entry a cycle, as it is after reset.
// Reset: min all ones, max zero, byte count 1, GVAR off, no partial pixel.
module pixel_min_max_histogram #(
    parameter int HIST_BINS = pmmh_pkg::HIST_BINS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pmmh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pmmh_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      op,
    input  logic [7:0]                      data_byte,
    input  logic [7:0]                      bin_index,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [31:0]                     min_value,
    output logic [31:0]                     max_value,
    output logic [31:0]                     bin_count
);

    localparam int AW       = $clog2(HIST_BINS);
    localparam int GVAR_LIM = (pmmh_pkg::GVAR_BINS < HIST_BINS) ?
                              pmmh_pkg::GVAR_BINS : HIST_BINS;
    localparam logic [31:0] GVAR_LAST = 32'(GVAR_LIM - 1);
    localparam logic [31:0] BYTE_LAST = 32'(pmmh_pkg::BYTE_BINS - 1);
    localparam logic [31:0] BINS_END  = 32'(HIST_BINS);
    localparam logic [31:0] SWEEP_END = 32'(HIST_BINS - 1);

    // configuration
    logic [pmmh_pkg::CFG_DATA_W-1:0] bpp_reg;
    logic                            gvar_reg;
    logic                            restart;

    // input side
    logic           in_acc;
    logic           take;
    logic           is_read;
    logic           is_clear;
    pmmh_pkg::pix_t pix;
    logic [31:0]    idx32;
    logic [31:0]    idx_lim;
    logic [31:0]    idx_sat;
    logic [31:0]    bin32;
    logic [AW-1:0]  raddr;
    logic           hist_upd;

    logic [31:0] min_reg;
    logic [31:0] max_reg;

    // clear sweep
    logic          clearing_reg;
    logic [AW-1:0] clr_cnt_reg;

    // read-modify-write stage
    logic          s1_valid_reg;
    logic          s1_read_reg;
    logic [AW-1:0] s1_addr_reg;
    logic          s1_in_range_reg;
    logic [31:0]   s1_min_reg;
    logic [31:0]   s1_max_reg;
    logic          s1_upd;
    logic          s1_res;
    logic [31:0]   ram_q;
    logic [31:0]   count;
    logic [31:0]   count_inc;

    logic          fwd_valid_reg;
    logic [AW-1:0] fwd_addr_reg;
    logic [31:0]   fwd_data_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;

    // output register and skid
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    logic        out_load_s1;
    logic        out_load_skid;
    logic        skid_load;
    logic        take_out;
    logic [31:0] res_count;
    logic [31:0] out_min_reg;
    logic [31:0] out_max_reg;
    logic [31:0] out_cnt_reg;
    logic [31:0] skid_min_reg;
    logic [31:0] skid_max_reg;
    logic [31:0] skid_cnt_reg;

    assign restart = cfg_we && (cfg_index == pmmh_pkg::CFG_BYTES_PER_PIXEL);

    assign in_stall = clearing_reg || skid_valid_reg ||
                      (out_valid_reg && out_stall && s1_valid_reg && s1_read_reg);
    assign in_acc   = in_valid && !in_stall;
    assign take     = in_acc && (op == pmmh_pkg::OP_PIXEL);
    assign is_read  = in_acc && (op == pmmh_pkg::OP_READ);
    assign is_clear = in_acc && (op == pmmh_pkg::OP_CLEAR);

    pmmh_assembler u_asm (
        .clk             (clk),
        .rst_n           (rst_n),
        .take            (take),
        .restart         (restart),
        .data_byte       (data_byte),
        .bytes_per_pixel (bpp_reg),
        .gvar_raw_mode   (gvar_reg),
        .pix             (pix)
    );

    // bin is value/4, pinned to the last bin of the mode
    assign idx32   = pix.value >> pmmh_pkg::BIN_SHIFT;
    assign idx_lim = pix.gvar ? GVAR_LAST : BYTE_LAST;
    assign idx_sat = (idx32 > idx_lim) ? idx_lim : idx32;
    assign bin32   = 32'(bin_index);
    assign raddr   = (op == pmmh_pkg::OP_READ) ? bin32[AW-1:0] : idx_sat[AW-1:0];

    assign hist_upd = pix.done && pix.hist_en;

    // a RAM read misses the last write, so a matching address takes it from the forwarding register
    assign count     = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ?
                       fwd_data_reg : ram_q;
    assign count_inc = (count == '1) ? count : count + 32'd1;
    assign s1_upd    = s1_valid_reg && !s1_read_reg;
    assign s1_res    = s1_valid_reg && s1_read_reg;
    assign res_count = s1_in_range_reg ? count : '0;

    assign ram_we    = clearing_reg || s1_upd;
    assign ram_waddr = clearing_reg ? clr_cnt_reg : s1_addr_reg;
    assign ram_wdata = clearing_reg ? '0 : count_inc;

    pmmh_ram #(
        .WIDTH (32),
        .DEPTH (HIST_BINS)
    ) u_hist (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (raddr),
        .rdata (ram_q)
    );

    assign take_out = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_load_s1     = 1'b0;
        out_load_skid   = 1'b0;
        skid_load       = 1'b0;
        if (skid_valid_reg)
        begin
            if (take_out)
            begin
                out_load_skid   = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (s1_res)
        begin
            if (!out_valid_reg || take_out)
            begin
                out_load_s1    = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_load       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (take_out)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg        <= 3'd1;
            gvar_reg       <= 1'b0;
            min_reg        <= '1;
            max_reg        <= '0;
            clearing_reg   <= 1'b1;
            clr_cnt_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pmmh_pkg::CFG_BYTES_PER_PIXEL: bpp_reg  <= cfg_data;
                    pmmh_pkg::CFG_GVAR_RAW_MODE:   gvar_reg <= cfg_data[0];
                    default:                       ;
                endcase
            end

            if (is_clear)
            begin
                min_reg      <= '1;
                max_reg      <= '0;
                clearing_reg <= 1'b1;
                clr_cnt_reg  <= '0;
            end
            else
            begin
                if (pix.done && (pix.value < min_reg))
                begin
                    min_reg <= pix.value;
                end
                if (pix.done && (pix.value > max_reg))
                begin
                    max_reg <= pix.value;
                end
                if (clearing_reg)
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (32'(clr_cnt_reg) == SWEEP_END)
                    begin
                        clearing_reg <= 1'b0;
                    end
                end
            end

            s1_valid_reg <= is_read || hist_upd;

            if (s1_upd)
            begin
                fwd_valid_reg <= 1'b1;
            end
            else if (clearing_reg)
            begin
                fwd_valid_reg <= 1'b0;
            end

            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_read || hist_upd)
        begin
            s1_read_reg     <= is_read;
            s1_addr_reg     <= raddr;
            s1_in_range_reg <= bin32 < BINS_END;
            s1_min_reg      <= min_reg;
            s1_max_reg      <= max_reg;
        end
        if (s1_upd)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= count_inc;
        end
        if (out_load_s1)
        begin
            out_min_reg <= s1_min_reg;
            out_max_reg <= s1_max_reg;
            out_cnt_reg <= res_count;
        end
        else if (out_load_skid)
        begin
            out_min_reg <= skid_min_reg;
            out_max_reg <= skid_max_reg;
            out_cnt_reg <= skid_cnt_reg;
        end
        if (skid_load)
        begin
            skid_min_reg <= s1_min_reg;
            skid_max_reg <= s1_max_reg;
            skid_cnt_reg <= res_count;
        end
    end

    assign out_valid = out_valid_reg;
    assign min_value = out_min_reg;
    assign max_value = out_max_reg;
    assign bin_count = out_cnt_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with empty output register");

    a_no_update_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !s1_valid_reg)
        else $error("histogram access in flight during clear sweep");

    a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
        is_clear |=> (clearing_reg && (min_reg == '1) && (max_reg == '0)))
        else $error("clear word did not reset statistics");

    a_sweep_full: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clearing_reg) |-> (32'($past(clr_cnt_reg)) == SWEEP_END))
        else $error("clear sweep ended early");

endmodule

FILE: sim/pmmh_stats_checker.sv
module pmmh_stats_checker #(
    parameter int HIST_BINS = pmmh_pkg::HIST_BINS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pmmh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pmmh_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [1:0]                      op,
    input  logic [7:0]                      data_byte,
    input  logic [7:0]                      bin_index,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [31:0]                     min_value,
    input  logic [31:0]                     max_value,
    input  logic [31:0]                     bin_count,
    output int                              fail_count,
    output int                              pending
);
    import pmmh_pkg::*;

    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] tally;
    } stats_word_t;

    logic [2:0]  width_cfg;
    logic        gvar_cfg;
    logic [31:0] pix_shift;
    logic [1:0]  pix_pos;
    logic [31:0] seen_min;
    logic [31:0] seen_max;
    logic [31:0] bin_tally [HIST_BINS];
    stats_word_t stats_due [$];
    stats_word_t due;
    int          fails;

    task clear_stats();
        seen_min = '1;
        seen_max = '0;
        for (int i = 0; i < HIST_BINS; i++)
            bin_tally[i] = '0;
    endtask

    task count_in_bin(input logic [31:0] pix, input int mode_bins);
        int          last;
        logic [31:0] idx;
        last = ((mode_bins < HIST_BINS) ? mode_bins : HIST_BINS) - 1;
        idx = pix >> BIN_SHIFT;
        if (idx > last)
            idx = last;
        if (bin_tally[idx] != '1)
            bin_tally[idx] = bin_tally[idx] + 32'd1;
    endtask

    task take_pixel_byte(input logic [7:0] b);
        int          width;
        logic        gvar_pix;
        logic [31:0] pix;
        // 0 behaves as 1, 5..7 as 4
        width = (width_cfg == 3'd0) ? 1 : (width_cfg > 3'd4) ? 4 : int'(width_cfg);
        gvar_pix = (width == 2) && gvar_cfg;
        pix_shift = {pix_shift[23:0], b};
        if (int'(pix_pos) + 1 < width)
        begin
            pix_pos = pix_pos + 2'd1;
        end
        else
        begin
            pix = pix_shift;
            pix_shift = '0;
            pix_pos = '0;
            if (gvar_pix)
                pix = pix >> GVAR_SHIFT;
            if (pix < seen_min)
                seen_min = pix;
            if (pix > seen_max)
                seen_max = pix;
            if (gvar_pix)
                count_in_bin(pix, GVAR_BINS);
            else if (width == 1)
                count_in_bin(pix, BYTE_BINS);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg = 3'd1;
            gvar_cfg = 1'b0;
            pix_shift = '0;
            pix_pos = '0;
            clear_stats();
            stats_due.delete();
            fails = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (stats_due.size() == 0)
                begin
                    $display("%0t: read word with none expected: min %h max %h count %h",
                             $time, min_value, max_value, bin_count);
                    fails++;
                end
                else
                begin
                    due = stats_due.pop_front();
                    if (min_value !== due.lo)
                    begin
                        $display("%0t: min_value expected %h got %h", $time, due.lo, min_value);
                        fails++;
                    end
                    if (max_value !== due.hi)
                    begin
                        $display("%0t: max_value expected %h got %h", $time, due.hi, max_value);
                        fails++;
                    end
                    if (bin_count !== due.tally)
                    begin
                        $display("%0t: bin_count expected %h got %h",
                                 $time, due.tally, bin_count);
                        fails++;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_BYTES_PER_PIXEL)
                begin
                    // width change drops any half-built pixel
                    width_cfg = cfg_data;
                    pix_shift = '0;
                    pix_pos = '0;
                end
                else if (cfg_index == CFG_GVAR_RAW_MODE)
                begin
                    gvar_cfg = cfg_data[0];
                end
            end
            if (in_valid && !in_stall)
            begin
                case (op)
                    OP_PIXEL:
                        take_pixel_byte(data_byte);
                    OP_READ:
                    begin
                        due.lo = seen_min;
                        due.hi = seen_max;
                        due.tally = (int'(bin_index) < HIST_BINS) ? bin_tally[bin_index] : '0;
                        stats_due.push_back(due);
                    end
                    OP_CLEAR:
                        clear_stats();
                    default:
                        ;
                endcase
            end
        end
        fail_count <= fails;
        pending <= stats_due.size();
    end

endmodule

FILE: sim/pixel_min_max_histogram_tb.sv
module pixel_min_max_histogram_tb;
    import pmmh_pkg::*;

    localparam int         HIST_BINS      = HIST_BINS_DEF;
    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         PHASE_ITEMS    = 110;
    localparam int         N_PHASES       = 12;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [1:0]            op        = OP_PIXEL;
    logic [7:0]            data_byte = '0;
    logic [7:0]            bin_index = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [31:0]           min_value;
    logic [31:0]           max_value;
    logic [31:0]           bin_count;
    int                    fail_count;
    int                    pending;

    logic                  quiet = 1'b0;
    int                    hold_left;
    int                    idle_cycles = 0;
    int                    cur_width = 1;
    logic                  cur_gvar = 1'b0;
    int                    tb_pos = 0;

    logic [2:0] mode_width [N_PHASES] = '{3'd1, 3'd2, 3'd2, 3'd3, 3'd4, 3'd0,
                                          3'd5, 3'd6, 3'd7, 3'd2, 3'd1, 3'd1};
    logic       mode_gvar  [N_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1,
                                          1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

    pixel_min_max_histogram #(.HIST_BINS(HIST_BINS)) u_top (.*);

    pmmh_stats_checker #(.HIST_BINS(HIST_BINS)) u_check (.*);

    initial
        forever #2 clk = ~clk;

    // result side: random hold-off after every accepted word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                hold_left = quiet ? 0 : $urandom_range(0, 8);
            else if (hold_left > 0)
                hold_left = hold_left - 1;
            out_stall <= (hold_left > 0);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("pixel_min_max_histogram: mismatch");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task send_word(input logic [1:0] w_op, input logic [7:0] w_byte, input logic [7:0] w_bin);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= w_op;
        data_byte <= w_byte;
        bin_index <= w_bin;
        do
            @(posedge clk);
        while (in_stall);
        if (w_op == OP_PIXEL)
            tb_pos = (tb_pos + 1) % cur_width;
    endtask

    task drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // block must be idle, including any clear sweep, before a register write
    task set_mode(input logic [2:0] width_val, input logic gvar_val);
        logic [CFG_DATA_W-1:0] gvar_word;
        drain();
        repeat (HIST_BINS + 4) @(posedge clk);
        write_reg(CFG_BYTES_PER_PIXEL, CFG_DATA_W'(width_val));
        gvar_word = CFG_DATA_W'($urandom);
        gvar_word[0] = gvar_val;
        write_reg(CFG_GVAR_RAW_MODE, gvar_word);
        cur_width = (width_val == 3'd0) ? 1 : (width_val > 3'd4) ? 4 : int'(width_val);
        cur_gvar = gvar_val;
        tb_pos = 0;
    endtask

    task random_word();
        int         pick;
        logic [7:0] b;
        logic [7:0] bin;
        pick = $urandom_range(0, 99);
        b = 8'($urandom);
        bin = 8'($urandom);
        if (pick < 62)
        begin
            if ($urandom_range(0, 9) == 0)
                b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else if (cur_gvar && cur_width == 2 && tb_pos == 0 && $urandom_range(0, 7) != 0)
                b = 8'($urandom_range(0, 127));   // keeps GVAR pixels to 10 bits
            else if ($urandom_range(0, 2) == 0)
                b = 8'($urandom_range(0, 31));    // pile up a few bins
            send_word(OP_PIXEL, b, bin);
        end
        else if (pick < 90)
        begin
            if (cur_width == 1 && $urandom_range(0, 1) == 1)
                bin = 8'($urandom_range(0, BYTE_BINS - 1));
            send_word(OP_READ, b, bin);
        end
        else if (pick < 94)
        begin
            send_word(OP_CLEAR, b, bin);
        end
        else
        begin
            send_word(OP_UNUSED, b, bin);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        set_mode(3'd1, 1'b0);
        send_word(OP_READ, 8'h00, 8'h00);       // empty statistics
        send_word(OP_PIXEL, 8'h00, 8'hFF);
        send_word(OP_PIXEL, 8'hFF, 8'h00);
        send_word(OP_PIXEL, 8'h03, 8'h00);
        send_word(OP_READ, 8'hFF, 8'd0);
        send_word(OP_READ, 8'h00, 8'd63);
        send_word(OP_READ, 8'h00, 8'd255);
        send_word(OP_UNUSED, 8'hA5, 8'h5A);
        send_word(OP_CLEAR, 8'h00, 8'h00);
        send_word(OP_READ, 8'h00, 8'd63);

        // GVAR: oversized pixel lands in the last bin
        set_mode(3'd2, 1'b1);
        send_word(OP_PIXEL, 8'hFF, 8'h00);
        send_word(OP_PIXEL, 8'hFF, 8'h00);
        send_word(OP_READ, 8'h00, 8'd255);
        // clear keeps the half-built pixel
        send_word(OP_PIXEL, 8'h12, 8'h00);
        send_word(OP_CLEAR, 8'h00, 8'h00);
        send_word(OP_PIXEL, 8'h34, 8'h00);
        send_word(OP_READ, 8'h00, 8'd36);
        send_word(OP_READ, 8'h00, 8'd255);

        // GVAR flag has no effect at four bytes
        set_mode(3'd4, 1'b1);
        repeat (4) send_word(OP_PIXEL, 8'hFF, 8'h00);
        send_word(OP_READ, 8'h00, 8'd0);

        // width write throws away a partial pixel
        set_mode(3'd7, 1'b0);
        send_word(OP_PIXEL, 8'h11, 8'h00);
        set_mode(3'd0, 1'b0);
        send_word(OP_PIXEL, 8'h22, 8'h00);
        send_word(OP_READ, 8'h00, 8'd8);

        for (int p = 0; p < N_PHASES; p++)
        begin
            set_mode(mode_width[p], mode_gvar[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 16 == 0)
                    quiet <= ($urandom_range(0, 3) == 0);
                if (i == PHASE_ITEMS / 2)
                    drain();
                random_word();
            end
        end

        drain();
        repeat (HIST_BINS + 8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("pixel_min_max_histogram: match");
        else
            $display("pixel_min_max_histogram: mismatch");
        $finish;
    end

endmodule
